/* rtl/stwsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sliding time-window sum alarm.
// No dependencies; imported by stwsa_csr, stwsa_engine and the top level.
package stwsa_pkg;

   // Field widths of the request and response items
   localparam int unsigned MINUTE_W    = 32;
   localparam int unsigned AMOUNT_W    = 16;
   localparam int unsigned STORED_AMT_W = 15;
   localparam int unsigned SEQ_W       = 32;

   // Configuration register widths, reset values and word indexes
   localparam int unsigned WINDOW_W    = 11;
   localparam int unsigned THRESHOLD_W = 25;
   localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = 11'd60;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 25'd1000;
   localparam logic REG_WINDOW    = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   // One ring entry: time, non-negative amount and discarded mark
   localparam int unsigned ENTRY_W = MINUTE_W + STORED_AMT_W + 1;

   // Live configuration handed from the register block to the engine
   typedef struct packed {
      logic [WINDOW_W-1:0]    window_minutes;
      logic [THRESHOLD_W-1:0] sum_threshold;
   } cfg_type;

   // Engine sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE
   } eng_state_type;

endpackage

/* rtl/stwsa_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing but the clock.
module stwsa_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stwsa_csr.sv */
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port.
// Depends on stwsa_pkg for the register layout and the cfg_type struct.
module stwsa_csr
   import stwsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [WINDOW_W-1:0]    window_ff, window_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic                   wr_strobe;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write decode; the word index is address bit 2
   always_comb begin
      window_in    = window_ff;
      threshold_in = threshold_ff;
      if (wr_strobe) begin
         case (csr_paddr[2])
            REG_WINDOW:    window_in    = csr_pwdata[WINDOW_W-1:0];
            REG_THRESHOLD: threshold_in = csr_pwdata[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
      end
   end

   // Read mux
   always_comb begin
      case (csr_paddr[2])
         REG_WINDOW:    csr_prdata = {{(32-WINDOW_W){1'b0}}, window_ff};
         REG_THRESHOLD: csr_prdata = {{(32-THRESHOLD_W){1'b0}}, threshold_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.window_minutes = window_ff;
   assign cfg.sum_threshold  = threshold_ff;

endmodule

/* rtl/stwsa_engine.sv */
`timescale 1ns / 1ps
// Sequencer that walks the sample ring: evicts expired entries, or the oldest when full, from the tail,
// appends the new sample and forms the response. Depends on stwsa_pkg, stwsa_ram.
module stwsa_engine
   import stwsa_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [MINUTE_W-1:0] req_minute,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                req_discarded,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_alarm,
   output logic [SEQ_W-1:0]    rsp_first_seq,
   output logic [SEQ_W-1:0]    rsp_last_seq
);

   localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
   localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W = STORED_AMT_W + OCC_W;
   localparam int unsigned CMP_W = (SUM_W > THRESHOLD_W) ? SUM_W : THRESHOLD_W;
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(WINDOW_DEPTH);
   localparam logic [AW-1:0]    PTR_LAST = AW'(WINDOW_DEPTH - 1);

   eng_state_type            state_ff, state_in;
   logic [MINUTE_W-1:0]      now_ff, now_in;
   logic [STORED_AMT_W-1:0]  amt_ff, amt_in;
   logic                     disc_ff, disc_in;
   logic [AW-1:0]            tail_ff, tail_in;
   logic [AW-1:0]            wp_ff, wp_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [OCC_W-1:0]         dcnt_ff, dcnt_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_alarm_ff, rsp_alarm_in;
   logic [SEQ_W-1:0]         rsp_first_ff, rsp_first_in;
   logic [SEQ_W-1:0]         rsp_last_ff, rsp_last_in;

   logic                     ram_rd_en;
   logic                     ram_wr_en;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic [MINUTE_W-1:0]      rd_time;
   logic [STORED_AMT_W-1:0]  rd_amt;
   logic                     rd_disc;
   logic [MINUTE_W-1:0]      age;
   logic                     expired;
   logic                     out_free;
   logic [SUM_W-1:0]         sum_new;
   logic [OCC_W-1:0]         dcnt_new;

   // Sample ring: time, non-negative amount and discarded mark in one word.
   // Reads and writes fall in different states, so no entry is read and
   // written in the same cycle.
   stwsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (tail_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_time     = ram_rd_data[MINUTE_W-1:0];
   assign rd_amt      = ram_rd_data[MINUTE_W +: STORED_AMT_W];
   assign rd_disc     = ram_rd_data[ENTRY_W-1];
   assign ram_wr_data = {disc_ff, amt_ff, now_ff};

   // Age of the tail entry, modulo 2^32
   assign age     = now_ff - rd_time;
   assign expired = age >= {{(MINUTE_W-WINDOW_W){1'b0}}, cfg.window_minutes};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sum_new    = sum_ff + SUM_W'(amt_ff);
   assign dcnt_new   = dcnt_ff + OCC_W'(disc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign ram_rd_en  = (state_ff == ST_READ) && (occ_ff != '0);
   assign ram_wr_en  = (state_ff == ST_WRITE) && out_free;

   // Next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      amt_in       = amt_ff;
      disc_in      = disc_ff;
      tail_in      = tail_ff;
      wp_in        = wp_ff;
      occ_in       = occ_ff;
      sum_in       = sum_ff;
      dcnt_in      = dcnt_ff;
      seq_in       = seq_ff;
      rsp_alarm_in = rsp_alarm_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in  = req_minute;
               disc_in = req_discarded;
               // Zero and negative amounts add nothing
               if (!req_amount[AMOUNT_W-1] && (req_amount != '0)) begin
                  amt_in = req_amount[STORED_AMT_W-1:0];
               end else begin
                  amt_in = '0;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (occ_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Evict an expired tail, or the oldest entry when the ring is full
            if (expired || (occ_ff == OCC_FULL)) begin
               sum_in  = sum_ff - SUM_W'(rd_amt);
               dcnt_in = dcnt_ff - OCC_W'(rd_disc);
               occ_in  = occ_ff - 1'b1;
               tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            end
            state_in = expired ? ST_READ : ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               wp_in        = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
               occ_in       = occ_ff + 1'b1;
               sum_in       = sum_new;
               dcnt_in      = dcnt_new;
               seq_in       = seq_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_alarm_in = (CMP_W'(sum_new) >= CMP_W'(cfg.sum_threshold))
                              && (dcnt_new == '0);
               if (rsp_alarm_in) begin
                  rsp_first_in = seq_ff - SEQ_W'(occ_ff);
                  rsp_last_in  = seq_ff;
               end else begin
                  rsp_first_in = '0;
                  rsp_last_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= '0;
         wp_ff        <= '0;
         occ_ff       <= '0;
         sum_ff       <= '0;
         dcnt_ff      <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         wp_ff        <= wp_in;
         occ_ff       <= occ_in;
         sum_ff       <= sum_in;
         dcnt_ff      <= dcnt_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      amt_ff       <= amt_in;
      disc_ff      <= disc_in;
      rsp_alarm_ff <= rsp_alarm_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_alarm     = rsp_alarm_ff;
   assign rsp_first_seq = rsp_first_ff;
   assign rsp_last_seq  = rsp_last_ff;

   // Checks on the ring bookkeeping
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("ring occupancy above depth");

   a_dcnt_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= occ_ff)
      else $error("discard count above occupancy");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (sum_ff == '0) && (dcnt_ff == '0))
      else $error("empty ring with nonzero sum or discard count");

   a_tail_meets_wp: assert property (@(posedge clock) disable iff (reset)
      ((occ_ff == '0) || (occ_ff == OCC_FULL)) |-> (tail_ff == wp_ff))
      else $error("tail and write pointer disagree with occupancy");

   a_write_loads: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("ring write without a response");

endmodule

/* rtl/sliding_time_window_sum_alarm_core.sv */
`timescale 1ns / 1ps
// Top level of the sliding time-window precipitation sum alarm.
// Depends on stwsa_pkg, stwsa_csr, stwsa_engine and stwsa_ram.
//
// A request carries one sample: obs_minute and amount in req_tdata, the
// discarded mark in req_tuser. Every request yields exactly one response:
// the alarm flag in rsp_tuser and the sequence range to mark in rsp_tdata
// (both zero when there is no alarm). The window length and the sum
// threshold sit in two 32-bit registers at byte addresses 0 and 4 of the
// csr_ port; write them only while idle.
// After a request is accepted the engine goes through ST_READ and ST_CHECK,
// repeated for every expired entry evicted (one ring read and one compare
// each), with ST_CHECK skipped when the ring is empty at the append, and
// then ST_WRITE, which loads the response. The next request is accepted
// once the engine is back in ST_IDLE.
// Synchronous reset empties the window, zeroes the sum, the discard count
// and the sequence counter and loads the register defaults (60, 1000);
// the ring memory is not cleared, as only occupied entries are ever read.
// A finished response waits in the output register while the next request
// is accepted and worked on; its append waits until that register is free.
module sliding_time_window_sum_alarm_core
   import stwsa_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // [31:0] obs_minute, [47:32] amount
   input  logic        req_tuser,    // [0] discarded_in
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] mark_first_seq, [63:32] mark_last_seq
   output logic        rsp_tuser,    // [0] alarm
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type          cfg;
   logic [SEQ_W-1:0] first_seq;
   logic [SEQ_W-1:0] last_seq;

   // Configuration registers
   stwsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Ring walker and response register
   stwsa_engine #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_minute    (req_tdata[MINUTE_W-1:0]),
      .req_amount    (req_tdata[MINUTE_W +: AMOUNT_W]),
      .req_discarded (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_alarm     (rsp_tuser),
      .rsp_first_seq (first_seq),
      .rsp_last_seq  (last_seq)
   );

   assign rsp_tdata = {last_seq, first_seq};

endmodule
